### design/bei_pkg.sv
// ----------------------------------------------------------------------------
// bei_pkg
// Shared types and codes for the breakpoint envelope interpolation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bei_pkg;

    // action codes carried by an input beat
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ORDER = 2'd3;

    // fraction width of the interpolation weight (unsigned Q0.16)
    localparam int FRAC_BITS = 16;

    // how the datapath loads its pending result
    typedef enum logic [2:0] {
        RES_KEEP,
        RES_ZERO,
        RES_EMPTY,
        RES_HOLD,
        RES_RIGHT,
        RES_LEFT,
        RES_INTERP
    } res_op_t;

    typedef struct packed {
        logic    load;
        logic    clear;
        logic    append;
        logic    rd_en;
        logic    rd_left;
        logic    cur_inc;
        logic    latch_right;
        logic    div_start;
        logic    mul;
        res_op_t res_op;
        logic    emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       empty;
        logic       cur_end;
        logic       q_past;
        logic       span_flat;
        logic       q_le_left;
        logic       div_done;
    } sts_t;

endpackage

`default_nettype wire

### design/bei_div.sv
// ----------------------------------------------------------------------------
// bei_div
// Restoring divider, one quotient bit per cycle. Gives floor(num*2^F/den)
// for num < den, with F the fraction width.
// ----------------------------------------------------------------------------
`default_nettype none

module bei_div #(
    parameter int NUM_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [NUM_BITS-1:0]           num,
    input  logic [NUM_BITS-1:0]           den,
    output logic [bei_pkg::FRAC_BITS-1:0] quot,
    output logic                          done
);

    localparam int FB    = bei_pkg::FRAC_BITS;
    localparam int CNT_W = $clog2(FB + 1);

    logic [NUM_BITS-1:0] rem_reg;
    logic [NUM_BITS-1:0] den_reg;
    logic [FB-1:0]       quot_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic [NUM_BITS:0]   shifted;
    logic [NUM_BITS:0]   trial;
    logic                fits;

    // remainder stays below den, so the doubled value fits one extra bit
    assign shifted = {rem_reg, 1'b0};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(FB);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= fits ? trial[NUM_BITS-1:0] : shifted[NUM_BITS-1:0];
            quot_reg <= {quot_reg[FB-2:0], fits};
        end
    end

    assign quot = quot_reg;
    assign done = (cnt_reg == '0);

endmodule

`default_nettype wire

### design/bei_dp.sv
// ----------------------------------------------------------------------------
// bei_dp
// Datapath: breakpoint tables, point count, span cursor, divider, multiplier,
// result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bei_dp #(
    parameter int MAX_POINTS = 64,
    parameter int VALUE_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bei_pkg::cmd_t                cmd,
    output bei_pkg::sts_t                sts,
    input  logic [1:0]                   action,
    input  logic [TIME_BITS-1:0]         point_time,
    input  logic signed [VALUE_BITS-1:0] point_value,
    input  logic [TIME_BITS-1:0]         query_time,
    output logic signed [VALUE_BITS-1:0] envelope_value,
    output logic [1:0]                   status
);

    localparam int FB     = bei_pkg::FRAC_BITS;
    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PROD_W = VALUE_BITS + FB + 2;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_POINTS);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [TIME_BITS-1:0]         time_mem  [MAX_POINTS];
    logic signed [VALUE_BITS-1:0] value_mem [MAX_POINTS];

    logic [1:0]                   action_reg;
    logic [TIME_BITS-1:0]         ptime_reg;
    logic signed [VALUE_BITS-1:0] pval_reg;
    logic [TIME_BITS-1:0]         qtime_reg;

    logic [TIME_BITS-1:0]         t_rd_reg;
    logic signed [VALUE_BITS-1:0] v_rd_reg;
    logic [TIME_BITS-1:0]         tr_reg;
    logic signed [VALUE_BITS-1:0] vr_reg;
    logic [TIME_BITS-1:0]         last_time_reg;
    logic signed [VALUE_BITS-1:0] last_value_reg;

    logic signed [VALUE_BITS:0]   diff_reg;
    logic signed [PROD_W-1:0]     prod_reg;

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             cursor_reg;

    logic signed [VALUE_BITS-1:0] res_value_reg;
    logic [1:0]                   res_status_reg;
    logic signed [VALUE_BITS-1:0] envelope_value_reg;
    logic [1:0]                   status_reg;

    logic                         append_full;
    logic                         append_order;
    logic                         append_ok;
    logic [CNT_W-1:0]             cursor_dec;
    logic [ADDR_W-1:0]            rd_idx;
    logic [FB-1:0]                frac;
    logic                         div_done;
    logic signed [FB:0]           frac_ext;
    logic [VALUE_BITS+1:0]        interp_sum;

    assign append_full  = (count_reg == CNT_FULL);
    assign append_order = (count_reg != '0) && (ptime_reg < last_time_reg);
    assign append_ok    = !append_full && !append_order;

    assign cursor_dec = cursor_reg - CNT_ONE;
    assign rd_idx     = cmd.rd_left ? cursor_dec[ADDR_W-1:0] : cursor_reg[ADDR_W-1:0];

    bei_div #(
        .NUM_BITS (TIME_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (qtime_reg - t_rd_reg),
        .den   (tr_reg - t_rd_reg),
        .quot  (frac),
        .done  (div_done)
    );

    assign frac_ext = signed'({1'b0, frac});

    // left value plus the arithmetically shifted product
    assign interp_sum = {{2{v_rd_reg[VALUE_BITS-1]}}, v_rd_reg} + prod_reg[PROD_W-1:FB];

    always_ff @(posedge clk)
    begin
        if (cmd.append && append_ok)
        begin
            time_mem[count_reg[ADDR_W-1:0]]  <= ptime_reg;
            value_mem[count_reg[ADDR_W-1:0]] <= pval_reg;
        end
        if (cmd.rd_en)
        begin
            t_rd_reg <= time_mem[rd_idx];
            v_rd_reg <= value_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            cursor_reg <= CNT_ONE;
        end
        else if (cmd.clear)
        begin
            count_reg  <= '0;
            cursor_reg <= CNT_ONE;
        end
        else
        begin
            if (cmd.append && append_ok)
            begin
                count_reg <= count_reg + CNT_ONE;
            end
            if (cmd.cur_inc)
            begin
                cursor_reg <= cursor_reg + CNT_ONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            ptime_reg  <= point_time;
            pval_reg   <= point_value;
            qtime_reg  <= query_time;
        end
        if (cmd.append && append_ok)
        begin
            last_time_reg  <= ptime_reg;
            last_value_reg <= pval_reg;
        end
        if (cmd.latch_right)
        begin
            tr_reg <= t_rd_reg;
            vr_reg <= v_rd_reg;
        end
        if (cmd.div_start)
        begin
            diff_reg <= (VALUE_BITS + 1)'(vr_reg) - (VALUE_BITS + 1)'(v_rd_reg);
        end
        if (cmd.mul)
        begin
            prod_reg <= diff_reg * frac_ext;
        end

        if (cmd.append)
        begin
            res_value_reg <= '0;
            priority if (append_full)
            begin
                res_status_reg <= bei_pkg::ST_FULL;
            end
            else if (append_order)
            begin
                res_status_reg <= bei_pkg::ST_ORDER;
            end
            else
            begin
                res_status_reg <= bei_pkg::ST_OK;
            end
        end
        else
        begin
            unique case (cmd.res_op)
                bei_pkg::RES_KEEP:
                begin
                end
                bei_pkg::RES_ZERO:
                begin
                    res_value_reg  <= '0;
                    res_status_reg <= bei_pkg::ST_OK;
                end
                bei_pkg::RES_EMPTY:
                begin
                    res_value_reg  <= '0;
                    res_status_reg <= bei_pkg::ST_EMPTY;
                end
                bei_pkg::RES_HOLD:
                begin
                    res_value_reg  <= last_value_reg;
                    res_status_reg <= bei_pkg::ST_OK;
                end
                bei_pkg::RES_RIGHT:
                begin
                    res_value_reg  <= vr_reg;
                    res_status_reg <= bei_pkg::ST_OK;
                end
                bei_pkg::RES_LEFT:
                begin
                    res_value_reg  <= v_rd_reg;
                    res_status_reg <= bei_pkg::ST_OK;
                end
                bei_pkg::RES_INTERP:
                begin
                    res_value_reg  <= interp_sum[VALUE_BITS-1:0];
                    res_status_reg <= bei_pkg::ST_OK;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.emit)
        begin
            envelope_value_reg <= res_value_reg;
            status_reg         <= res_status_reg;
        end
    end

    // t_rd_reg holds the cursor entry during the walk, the left entry after
    assign sts.action    = action_reg;
    assign sts.empty     = (count_reg == '0);
    assign sts.cur_end   = (cursor_reg >= count_reg);
    assign sts.q_past    = (qtime_reg > t_rd_reg);
    assign sts.span_flat = (tr_reg == t_rd_reg) || (qtime_reg >= tr_reg);
    assign sts.q_le_left = (qtime_reg <= t_rd_reg);
    assign sts.div_done  = div_done;

    assign envelope_value = envelope_value_reg;
    assign status         = status_reg;

endmodule

`default_nettype wire

### design/bei_ctrl.sv
// ----------------------------------------------------------------------------
// bei_ctrl
// Sequencer: takes one beat, steps the datapath through clear, append or
// cursor walk and interpolation, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bei_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    output logic          result_valid,
    input  logic          result_stall,
    output bei_pkg::cmd_t cmd,
    input  bei_pkg::sts_t sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK_RD,
        S_WALK_CMP,
        S_LEFT,
        S_DIV,
        S_SUM,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;

    always_comb
    begin
        cmd               = '0;
        state_next        = state_reg;
        result_valid_next = result_valid_reg && result_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.action)
                    bei_pkg::ACT_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        cmd.res_op = bei_pkg::RES_ZERO;
                        state_next = S_FINISH;
                    end
                    bei_pkg::ACT_APPEND:
                    begin
                        cmd.append = 1'b1;
                        state_next = S_FINISH;
                    end
                    bei_pkg::ACT_QUERY:
                    begin
                        if (sts.empty)
                        begin
                            cmd.res_op = bei_pkg::RES_EMPTY;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_WALK_RD;
                        end
                    end
                    default:
                    begin
                        cmd.res_op = bei_pkg::RES_ZERO;
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_WALK_RD:
            begin
                // past the last breakpoint: hold its value
                if (sts.cur_end)
                begin
                    cmd.res_op = bei_pkg::RES_HOLD;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_WALK_CMP;
                end
            end
            S_WALK_CMP:
            begin
                if (sts.q_past)
                begin
                    cmd.cur_inc = 1'b1;
                    state_next  = S_WALK_RD;
                end
                else
                begin
                    cmd.latch_right = 1'b1;
                    cmd.rd_en       = 1'b1;
                    cmd.rd_left     = 1'b1;
                    state_next      = S_LEFT;
                end
            end
            S_LEFT:
            begin
                priority if (sts.span_flat)
                begin
                    cmd.res_op = bei_pkg::RES_RIGHT;
                    state_next = S_FINISH;
                end
                else if (sts.q_le_left)
                begin
                    cmd.res_op = bei_pkg::RES_LEFT;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.res_op = bei_pkg::RES_INTERP;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    cmd.emit          = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

### design/breakpoint_envelope_interp_unit.sv
// ----------------------------------------------------------------------------
// breakpoint_envelope_interp_unit
// Breakpoint envelope generator: loads (time, value) pairs into a table and
// answers time queries by linear interpolation with a forward-only cursor.
// ----------------------------------------------------------------------------
//
//  channel  handshake                 payload
//  -------  ------------------------  ------------------------------------------
//  item     item_valid / item_stall   action, point_time, point_value, query_time
//  result   result_valid/result_stall envelope_value, status
//
//  Clear, append, ignored actions and empty-table queries pass through the
//  dispatch and finish states. A query walks the cursor over the breakpoints
//  it passes (read and compare states, registered table read); an interpolated
//  answer then reads the left point, runs the divider, sums and finishes. Held
//  answers finish after the walk, left and right answers after the left read.
//  A stalled result holds the sequencer in its last state. Reset: empty table,
//  cursor at 1, no result pending; table contents are kept.
`default_nettype none

module breakpoint_envelope_interp_unit #(
    parameter int MAX_POINTS = 64,
    parameter int VALUE_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic [1:0]                   action,
    input  logic [TIME_BITS-1:0]         point_time,
    input  logic signed [VALUE_BITS-1:0] point_value,
    input  logic [TIME_BITS-1:0]         query_time,

    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [VALUE_BITS-1:0] envelope_value,
    output logic [1:0]                   status
);

    bei_pkg::cmd_t cmd;
    bei_pkg::sts_t sts;

    bei_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .sts          (sts)
    );

    bei_dp #(
        .MAX_POINTS (MAX_POINTS),
        .VALUE_BITS (VALUE_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .action         (action),
        .point_time     (point_time),
        .point_value    (point_value),
        .query_time     (query_time),
        .envelope_value (envelope_value),
        .status         (status)
    );

    // one beat in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("second beat accepted while one is in flight");

    // never overwrite a result still held by the output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!result_valid || !result_stall))
        else $error("result emitted over a stalled beat");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> result_valid)
        else $error("emitted result not presented");

    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !sts.div_done)
        else $error("divider reports done right after start");

endmodule

`default_nettype wire

### sim/breakpoint_envelope_interp_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// breakpoint_envelope_interp_unit_tb
// Self-checking bench for the breakpoint envelope unit. A queue of beats
// (directed corner cases, then random table loads and time sweeps) feeds a
// clocked driver. A scoreboard keeps its own copy of the breakpoint table
// and cursor, predicts each result at input acceptance, and compares it
// with what the monitor sees on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module breakpoint_envelope_interp_unit_tb;

    localparam int TIME_W    = 32;
    localparam int VALUE_W   = 16;
    localparam int MAX_PTS   = 64;
    localparam int N_BEATS   = 550;
    localparam int TAIL_CYC  = 200;
    localparam int CYC_LIMIT = 1000000;

    // action code the unit must ignore
    localparam logic [1:0] ACT_IGNORED = 2'd3;

    typedef enum int {
        PH_RX_HEAVY,
        PH_TX_HEAVY,
        PH_NO_IDLE
    } idle_phase_t;

    typedef struct {
        logic [1:0]         act;
        logic [TIME_W-1:0]  ptime;
        logic [VALUE_W-1:0] pval;
        logic [TIME_W-1:0]  qtime;
        bit                 drain;
        idle_phase_t        phase;
    } beat_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                status;
    } env_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         item_valid;
    logic                         item_stall;
    logic [1:0]                   action;
    logic [TIME_W-1:0]            point_time;
    logic signed [VALUE_W-1:0]    point_value;
    logic [TIME_W-1:0]            query_time;
    logic                         result_valid;
    logic                         result_stall;
    logic signed [VALUE_W-1:0]    envelope_value;
    logic [1:0]                   status;

    beat_t       beat_q[$];
    env_result_t env_expected_q[$];

    // scoreboard copy of the unit state
    logic [TIME_W-1:0]         bp_time  [MAX_PTS];
    logic signed [VALUE_W-1:0] bp_value [MAX_PTS];
    int unsigned               bp_count;
    int unsigned               bp_cursor;

    idle_phase_t gen_phase;
    idle_phase_t drive_phase;
    bit          drain_next;
    bit          beat_taken;
    int          total_beats;
    int          beats_accepted;
    int          fail_count;
    int          cycle_count;

    breakpoint_envelope_interp_unit #(
        .MAX_POINTS (MAX_PTS),
        .VALUE_BITS (VALUE_W),
        .TIME_BITS  (TIME_W)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .action         (action),
        .point_time     (point_time),
        .point_value    (point_value),
        .query_time     (query_time),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .envelope_value (envelope_value),
        .status         (status)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic logic signed [VALUE_W-1:0] interp_at(input logic [TIME_W-1:0] q);
        int unsigned               i;
        logic [TIME_W-1:0]         tl;
        logic [TIME_W-1:0]         tr;
        logic signed [VALUE_W-1:0] vl;
        logic signed [VALUE_W-1:0] vr;
        logic [63:0]               frac;
        longint                    prod;
        i = bp_cursor;
        while (i < bp_count && q > bp_time[i])
            i++;
        bp_cursor = i;
        if (i >= bp_count)
            return bp_value[bp_count - 1];
        tl = bp_time[i - 1];
        tr = bp_time[i];
        vl = bp_value[i - 1];
        vr = bp_value[i];
        if (tr == tl || q >= tr)
            return vr;
        // cursor never steps back: earlier queries clamp to the left point
        if (q <= tl)
            return vl;
        frac = ({32'd0, q - tl} << bei_pkg::FRAC_BITS) / {32'd0, tr - tl};
        prod = (longint'(vr) - longint'(vl)) * longint'(frac);
        return vl + VALUE_W'(prod >>> bei_pkg::FRAC_BITS);
    endfunction

    function automatic env_result_t predict_envelope(input beat_t b);
        env_result_t r;
        r.value  = '0;
        r.status = bei_pkg::ST_OK;
        case (b.act)
            bei_pkg::ACT_CLEAR:
            begin
                bp_count  = 0;
                bp_cursor = 1;
            end
            bei_pkg::ACT_APPEND:
            begin
                if (bp_count >= MAX_PTS)
                    r.status = bei_pkg::ST_FULL;
                else if (bp_count > 0 && b.ptime < bp_time[bp_count - 1])
                    r.status = bei_pkg::ST_ORDER;
                else
                begin
                    bp_time[bp_count]  = b.ptime;
                    bp_value[bp_count] = b.pval;
                    bp_count++;
                end
            end
            bei_pkg::ACT_QUERY:
            begin
                if (bp_count == 0)
                    r.status = bei_pkg::ST_EMPTY;
                else
                    r.value = interp_at(b.qtime);
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------
    function automatic logic [TIME_W-1:0] sat_time(input longint t);
        if (t < 0)
            return '0;
        if (t > longint'(32'hFFFF_FFFF))
            return 32'hFFFF_FFFF;
        return t[TIME_W-1:0];
    endfunction

    task automatic add_beat(input logic [1:0] act, input logic [TIME_W-1:0] pt,
                            input logic [VALUE_W-1:0] pv, input logic [TIME_W-1:0] qt);
        beat_t       b;
        idle_phase_t ph;
        if (beat_q.size() < N_BEATS / 3)
            ph = PH_RX_HEAVY;
        else if (beat_q.size() < 2 * N_BEATS / 3)
            ph = PH_TX_HEAVY;
        else
            ph = PH_NO_IDLE;
        b.act   = act;
        b.ptime = pt;
        b.pval  = pv;
        b.qtime = qt;
        b.phase = ph;
        b.drain = drain_next || (ph != gen_phase);
        drain_next = 1'b0;
        gen_phase  = ph;
        beat_q.push_back(b);
    endtask

    // clear, load a non-decreasing table, then sweep queries across it
    task automatic add_table_run(input bit fill);
        int     n;
        int     m;
        longint t;
        longint first_t;
        longint step_max;
        longint q;
        longint q_step;
        n = fill ? MAX_PTS + 2 : $urandom_range(1, 10);
        case ($urandom_range(2))
            0: step_max = 3;
            1: step_max = 1000;
            default: step_max = 64'd1 << 28;
        endcase
        t = ($urandom_range(1) == 0) ? longint'($urandom_range(1000)) : longint'($urandom);
        first_t = t;
        add_beat(bei_pkg::ACT_CLEAR, $urandom, VALUE_W'($urandom), $urandom);
        for (int k = 0; k < n; k++)
        begin
            if (k > 0 && $urandom_range(99) < 8 && t > 0)
                add_beat(bei_pkg::ACT_APPEND, sat_time(t - 1 - $urandom_range(500)),
                         VALUE_W'($urandom), $urandom);
            add_beat(bei_pkg::ACT_APPEND, sat_time(t), VALUE_W'($urandom), $urandom);
            t = t + longint'($urandom_range(0, 32'(step_max)));
        end
        m = fill ? 24 : $urandom_range(1, 8);
        q = first_t - $urandom_range(20);
        q_step = (t - first_t) / m + 1;
        for (int k = 0; k < m; k++)
        begin
            if ($urandom_range(99) < 15)
                add_beat(bei_pkg::ACT_QUERY, $urandom, VALUE_W'($urandom), $urandom);
            else
                add_beat(bei_pkg::ACT_QUERY, $urandom, VALUE_W'($urandom), sat_time(q));
            q = q + longint'($urandom_range(0, 32'(q_step * 2 > 32'hFFFF_FFFF ?
                                                    32'hFFFF_FFFF : q_step * 2)));
        end
    endtask

    task automatic add_directed;
        add_beat(bei_pkg::ACT_QUERY, 32'h0, 16'h0, 32'hFFFF_FFFF);    // empty table
        add_beat(ACT_IGNORED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        add_beat(bei_pkg::ACT_APPEND, 32'd0, 16'h8000, 32'd0);
        add_beat(bei_pkg::ACT_APPEND, 32'd0, 16'h7FFF, 32'd0);        // equal time kept
        add_beat(bei_pkg::ACT_APPEND, 32'd1000, 16'h0000, 32'd0);
        add_beat(bei_pkg::ACT_APPEND, 32'd999, 16'h0005, 32'd0);      // out of order
        add_beat(bei_pkg::ACT_APPEND, 32'hFFFF_FFFF, 16'h7FFF, 32'd0);
        add_beat(bei_pkg::ACT_QUERY, 32'd0, 16'd0, 32'd0);            // zero-width span
        add_beat(bei_pkg::ACT_QUERY, 32'd0, 16'd0, 32'd500);
        add_beat(bei_pkg::ACT_QUERY, 32'd0, 16'd0, 32'd1000);
        add_beat(bei_pkg::ACT_QUERY, 32'd0, 16'd0, 32'd5000);
        add_beat(bei_pkg::ACT_QUERY, 32'd0, 16'd0, 32'd10);           // behind left point
        add_beat(bei_pkg::ACT_QUERY, 32'd0, 16'd0, 32'h8000_0001);
        add_beat(bei_pkg::ACT_QUERY, 32'd0, 16'd0, 32'hFFFF_FFFF);
        add_beat(bei_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        add_beat(bei_pkg::ACT_APPEND, 32'd100, 16'hFFFB, 32'd0);
        add_beat(bei_pkg::ACT_QUERY, 32'd0, 16'd0, 32'd0);            // single point held
        add_beat(bei_pkg::ACT_APPEND, 32'd200, 16'h0007, 32'd0);
        add_beat(bei_pkg::ACT_QUERY, 32'd0, 16'd0, 32'd150);
        add_beat(bei_pkg::ACT_QUERY, 32'd0, 16'd0, 32'd300);          // past last point
        add_beat(bei_pkg::ACT_QUERY, 32'd0, 16'd0, 32'd101);
        add_beat(bei_pkg::ACT_APPEND, 32'd200, 16'h8000, 32'd0);
        add_beat(bei_pkg::ACT_QUERY, 32'd0, 16'd0, 32'd250);
        add_beat(bei_pkg::ACT_CLEAR, 32'd0, 16'd0, 32'd0);
        add_beat(bei_pkg::ACT_QUERY, 32'd0, 16'd0, 32'd7);            // empty after clear
    endtask

    // ------------------------------------------------------------------
    // driver: new beat only when the previous one was taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        beat_t b;
        int    tx_pct;
        int    rx_pct;
        case (drive_phase)
            PH_RX_HEAVY: begin tx_pct = 33; rx_pct = 67; end
            PH_TX_HEAVY: begin tx_pct = 67; rx_pct = 33; end
            default:     begin tx_pct = 0;  rx_pct = 0;  end
        endcase
        if (rst_n)
        begin
            if (!item_valid || beat_taken)
            begin
                beat_taken = 1'b0;
                if (beat_q.size() == 0 || $urandom_range(99) < tx_pct ||
                    (beat_q[0].drain && env_expected_q.size() != 0))
                    item_valid <= 1'b0;
                else
                begin
                    b = beat_q.pop_front();
                    drive_phase = b.phase;
                    item_valid  <= 1'b1;
                    action      <= b.act;
                    point_time  <= b.ptime;
                    point_value <= b.pval;
                    query_time  <= b.qtime;
                end
            end
            result_stall <= ($urandom_range(99) < rx_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor and scoreboard
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        env_result_t exp_r;
        beat_t       b;
        if (rst_n && result_valid && !result_stall)
        begin
            if (env_expected_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: value %0d status %0d",
                             envelope_value, status);
            end
            else
            begin
                exp_r = env_expected_q.pop_front();
                if (envelope_value !== exp_r.value || status !== exp_r.status)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch: expected value %0d status %0d, ",
                                  "got value %0d status %0d"},
                                 exp_r.value, exp_r.status, envelope_value, status);
                end
            end
        end
        if (rst_n && item_valid && !item_stall)
        begin
            b.act   = action;
            b.ptime = point_time;
            b.pval  = point_value;
            b.qtime = query_time;
            env_expected_q.push_back(predict_envelope(b));
            beats_accepted++;
            beat_taken = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYC_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        action       = bei_pkg::ACT_CLEAR;
        point_time   = '0;
        point_value  = '0;
        query_time   = '0;
        result_stall = 1'b0;
        bp_count     = 0;
        bp_cursor    = 1;
        gen_phase    = PH_RX_HEAVY;
        drive_phase  = PH_RX_HEAVY;
        drain_next   = 1'b0;
        beat_taken   = 1'b0;
        beats_accepted = 0;
        fail_count   = 0;
        cycle_count  = 0;

        add_directed();
        // first random run fills the table to hit the full status
        drain_next = 1'b1;
        add_table_run(1'b1);
        while (beat_q.size() < N_BEATS)
        begin
            if ($urandom_range(99) < 75)
            begin
                if ($urandom_range(99) < 4)
                begin
                    drain_next = 1'b1;
                    add_table_run(1'b1);
                end
                else
                    add_table_run(1'b0);
            end
            else
                add_beat(2'($urandom_range(3)), $urandom, VALUE_W'($urandom), $urandom);
        end
        total_beats = beat_q.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (beats_accepted == total_beats && env_expected_q.size() == 0);
        repeat (TAIL_CYC) @(posedge clk);

        if (fail_count == 0 && env_expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### breakpoint_envelope_interp_unit.f
design/bei_pkg.sv
design/bei_div.sv
design/bei_dp.sv
design/bei_ctrl.sv
design/breakpoint_envelope_interp_unit.sv
sim/breakpoint_envelope_interp_unit_tb.sv
